@@ rtl/core/kce_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kce_pkg
// Shared types and constants of the keypad code entry unit: words moved on
// the channels, configuration record, digit store command and message codes.
// ---------------------------------------------------------------------------
package kce_pkg;

    // default number of keys in one code
    localparam int KCE_CODE_LENGTH = 6;
    // bytes that fit in the packed code output
    localparam int KCE_CODE_BYTES  = 6;
    localparam int KCE_CODE_W      = 8 * KCE_CODE_BYTES;

    // configuration reset values
    localparam logic [31:0] KCE_TIMEOUT_RST = 32'd5000;
    localparam logic [7:0]  KCE_ERASE_RST   = 8'd35;   // '#'
    localparam logic [7:0]  KCE_ENTER_RST   = 8'd42;   // '*'

    // configuration register indexes
    localparam int          KCE_CFG_IDX_W   = 2;
    localparam logic [KCE_CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [KCE_CFG_IDX_W-1:0] CFG_ERASE_KEY     = 2'd1;
    localparam logic [KCE_CFG_IDX_W-1:0] CFG_ENTER_KEY     = 2'd2;

    // message codes
    localparam logic [2:0] MSG_IDLE       = 3'd0;
    localparam logic [2:0] MSG_DIGIT      = 3'd1;
    localparam logic [2:0] MSG_ERASE      = 3'd2;
    localparam logic [2:0] MSG_WELCOME    = 3'd3;
    localparam logic [2:0] MSG_INCOMPLETE = 3'd4;
    localparam logic [2:0] MSG_TIMEOUT    = 3'd5;

    typedef struct packed {
        logic [7:0]  key_code;
        logic [31:0] now_ticks;
    } t_in_word;

    typedef struct packed {
        logic [2:0]            message;
        logic                  send_pulse;
        logic [KCE_CODE_W-1:0] code_value;
        logic [2:0]            digits_entered;
    } t_out_word;

    typedef struct packed {
        logic [31:0] timeout_ticks;
        logic [7:0]  erase_key;
        logic [7:0]  enter_key;
    } t_cfg;

    // digit store command, already qualified by the processing strobe
    typedef struct packed {
        logic       clear;
        logic       wr_en;
        logic [7:0] wr_data;
    } t_store_cmd;

endpackage

@@ rtl/core/kce_in_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kce_in_if
// Poll channel: one keypad poll word per handshake.
// ---------------------------------------------------------------------------
interface kce_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  key_code;
    logic [31:0] now_ticks;

    modport source (output valid, output key_code, output now_ticks, input ready);
    modport sink   (input valid, input key_code, input now_ticks, output ready);
endinterface

@@ rtl/core/kce_out_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kce_out_if
// Result channel: one status word per handshake.
// ---------------------------------------------------------------------------
interface kce_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  message;
    logic        send_pulse;
    logic [47:0] code_value;
    logic [2:0]  digits_entered;

    modport source (output valid, output message, output send_pulse,
                    output code_value, output digits_entered, input ready);
    modport sink   (input valid, input message, input send_pulse,
                    input code_value, input digits_entered, output ready);
endinterface

@@ rtl/core/kce_cfg_regs.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kce_cfg_regs
// Configuration registers: timeout limit, erase key and enter key.
// Writes to an index beyond the register list are dropped.
// ---------------------------------------------------------------------------
module kce_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [kce_pkg::KCE_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                       i_cfg_wdata,
    output kce_pkg::t_cfg                     o_cfg
);
    import kce_pkg::*;

    t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= KCE_TIMEOUT_RST;
            r_cfg.erase_key     <= KCE_ERASE_RST;
            r_cfg.enter_key     <= KCE_ENTER_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_wdata;
                CFG_ERASE_KEY:     r_cfg.erase_key     <= i_cfg_wdata[7:0];
                CFG_ENTER_KEY:     r_cfg.enter_key     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/kce_code_store.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kce_code_store
// Register file of entered key bytes with one write port, a clear-all
// command and a packed view (first key in the low byte).
// ---------------------------------------------------------------------------
module kce_code_store #(
    parameter int CODE_LENGTH = kce_pkg::KCE_CODE_LENGTH,
    parameter int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kce_pkg::t_store_cmd            i_cmd,
    input  logic [IDX_W-1:0]               i_wr_idx,
    output logic [kce_pkg::KCE_CODE_W-1:0] o_code
);
    import kce_pkg::*;

    logic [7:0] r_digit [CODE_LENGTH];

    // clear has priority over a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
                r_digit[i] <= '0;
            end
        end else if (i_cmd.wr_en) begin
            r_digit[i_wr_idx] <= i_cmd.wr_data;
        end
    end

    // packed view; bytes past the code length or the output width are zero
    for (genvar b = 0; b < KCE_CODE_BYTES; b++) begin : g_pack
        if (b < CODE_LENGTH) begin : g_used
            assign o_code[8*b +: 8] = r_digit[b];
        end else begin : g_unused
            assign o_code[8*b +: 8] = 8'h00;
        end
    end

endmodule

@@ rtl/core/kce_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kce_ctrl
// Entry state machine: digit count, last activity tick and phase. Builds the
// result word of the poll being processed and drives the digit store.
// ---------------------------------------------------------------------------
module kce_ctrl #(
    parameter int CODE_LENGTH = kce_pkg::KCE_CODE_LENGTH,
    parameter int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1,
    parameter int DCNT_W      = $clog2(CODE_LENGTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  kce_pkg::t_in_word             i_word,
    input  kce_pkg::t_cfg                 i_cfg,
    input  logic [kce_pkg::KCE_CODE_W-1:0] i_code,
    output kce_pkg::t_out_word            o_result,
    output kce_pkg::t_store_cmd           o_store_cmd,
    output logic [IDX_W-1:0]              o_store_idx
);
    import kce_pkg::*;

    typedef enum logic [2:0] {
        ST_WELCOME,
        ST_ENTRY,
        ST_CONFIRM,
        ST_SEND,
        ST_INCOMPLETE,
        ST_TIMEOUT
    } t_state;

    localparam logic [DCNT_W-1:0] CNT_FULL = DCNT_W'(CODE_LENGTH);

    t_state            r_state, n_state;
    logic [DCNT_W-1:0] r_count, n_count;
    logic [31:0]       r_last, n_last;

    logic [31:0]       elapsed;
    logic              timed_out;
    logic              key_none, key_erase, key_enter;
    logic [DCNT_W-1:0] cnt_inc, cnt_dec;
    logic [2:0]        msg;
    logic              send;
    logic              clear;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic [DCNT_W-1:0] wr_pos;
    logic [KCE_CODE_W-1:0] code_out;

    // key decode and inactivity test
    assign key_none  = (i_word.key_code == 8'h00);
    assign key_erase = (i_word.key_code == i_cfg.erase_key);
    assign key_enter = (i_word.key_code == i_cfg.enter_key);
    assign elapsed   = i_word.now_ticks - r_last;
    assign timed_out = (elapsed >= i_cfg.timeout_ticks);
    assign cnt_inc   = r_count + 1'b1;
    assign cnt_dec   = r_count - 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_last  = r_last;
        msg     = MSG_IDLE;
        send    = 1'b0;
        clear   = 1'b0;
        wr_en   = 1'b0;
        wr_data = i_word.key_code;
        wr_pos  = r_count;
        unique case (r_state)
            ST_WELCOME: begin
                if (!key_none && !key_erase && !key_enter) begin
                    wr_en   = 1'b1;
                    wr_pos  = '0;
                    n_count = DCNT_W'(1);
                    n_last  = i_word.now_ticks;
                    n_state = (CODE_LENGTH <= 1) ? ST_CONFIRM : ST_ENTRY;
                    msg     = MSG_DIGIT;
                end
            end
            ST_ENTRY, ST_CONFIRM: begin
                priority if (timed_out) begin
                    n_state = ST_TIMEOUT;
                    msg     = MSG_TIMEOUT;
                end else if (key_none) begin
                    msg = MSG_IDLE;
                end else if (key_erase) begin
                    // drop the last digit
                    wr_en   = 1'b1;
                    wr_data = 8'h00;
                    wr_pos  = cnt_dec;
                    n_count = cnt_dec;
                    n_last  = i_word.now_ticks;
                    n_state = (cnt_dec == '0) ? ST_WELCOME : ST_ENTRY;
                    msg     = (cnt_dec == '0) ? MSG_WELCOME : MSG_ERASE;
                end else if (key_enter) begin
                    if (r_state == ST_CONFIRM) begin
                        n_state = ST_SEND;
                    end else begin
                        n_state = ST_INCOMPLETE;
                        msg     = MSG_INCOMPLETE;
                    end
                end else if (r_state == ST_ENTRY) begin
                    wr_en   = 1'b1;
                    n_count = cnt_inc;
                    n_last  = i_word.now_ticks;
                    n_state = (cnt_inc == CNT_FULL) ? ST_CONFIRM : ST_ENTRY;
                    msg     = MSG_DIGIT;
                end else begin
                    // digit with a full code is ignored
                    msg = MSG_IDLE;
                end
            end
            ST_SEND: begin
                send    = 1'b1;
                clear   = 1'b1;
                n_count = '0;
                n_state = ST_WELCOME;
                msg     = MSG_WELCOME;
            end
            ST_INCOMPLETE, ST_TIMEOUT: begin
                clear   = 1'b1;
                n_count = '0;
                n_state = ST_WELCOME;
                msg     = MSG_WELCOME;
            end
            default: begin
                n_state = ST_WELCOME;
            end
        endcase
    end

    // code shown with this result: the store after this poll's update,
    // except on the send step, which shows the code before it is cleared
    always_comb begin
        code_out = i_code;
        if (send) begin
            code_out = i_code;
        end else if (clear) begin
            code_out = '0;
        end else if (wr_en) begin
            for (int b = 0; b < KCE_CODE_BYTES; b++) begin
                if (int'(wr_pos) == b) begin
                    code_out[8*b +: 8] = wr_data;
                end
            end
        end
    end

    assign o_result.message        = msg;
    assign o_result.send_pulse     = send;
    assign o_result.code_value     = code_out;
    assign o_result.digits_entered = 3'(n_count);

    assign o_store_cmd.clear   = clear & i_fire;
    assign o_store_cmd.wr_en   = wr_en & i_fire;
    assign o_store_cmd.wr_data = wr_data;
    assign o_store_idx         = wr_pos[IDX_W-1:0];

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WELCOME;
            r_count <= '0;
            r_last  <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    // count never passes the code length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("digit count above code length");

    // welcome means an empty code
    a_welcome_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WELCOME) |-> (r_count == '0))
        else $error("digits held in welcome state");

    // confirmation and send hold a full code
    a_confirm_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONFIRM || r_state == ST_SEND) |-> (r_count == CNT_FULL))
        else $error("confirmation without a full code");

endmodule

@@ rtl/core/keypad_code_entry_fsm_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keypad_code_entry_fsm_unit
// Keypad code entry: collects a fixed-length key code from keypad polls,
// with erase and enter keys, inactivity timeout and a send step.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      word
//  i_in     in   valid/ready    key_code[7:0], now_ticks[31:0]
//  o_out    out  valid/ready    message[2:0], send_pulse, code_value[47:0],
//                               digits_entered[2:0]
//  cfg      in   i_cfg_wr_en    i_cfg_index[1:0], i_cfg_wdata[31:0]
//
//  One poll per cycle sustained while o_out is not stalled; each poll's
//  result word goes through the input register, then the result register.
//  The state update for a poll happens as it moves from the input register
//  into the result register.
//  Synchronous active-low reset; the digit store clears with it, no sweep.
//  A stalled result holds its register; the input side keeps taking polls
//  until the input register is also full.
// ---------------------------------------------------------------------------
module keypad_code_entry_fsm_unit #(
    parameter int CODE_LENGTH = kce_pkg::KCE_CODE_LENGTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kce_in_if.sink                            i_in,
    kce_out_if.source                         o_out,
    input  logic                              i_cfg_wr_en,
    input  logic [kce_pkg::KCE_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                       i_cfg_wdata
);
    import kce_pkg::*;

    localparam int IDX_W  = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int DCNT_W = $clog2(CODE_LENGTH + 1);

    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       r_out_valid;
    t_out_word  r_out_word;

    logic       out_load;
    logic       fire;
    logic       in_accept;

    t_cfg                  cfg;
    t_out_word             result;
    t_store_cmd            store_cmd;
    logic [IDX_W-1:0]      store_idx;
    logic [KCE_CODE_W-1:0] code;

    // pipeline handshake
    assign out_load   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_load;
    assign i_in.ready = !r_in_valid || out_load;
    assign in_accept  = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word.key_code  <= i_in.key_code;
            r_in_word.now_ticks <= i_in.now_ticks;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.message        = r_out_word.message;
    assign o_out.send_pulse     = r_out_word.send_pulse;
    assign o_out.code_value     = r_out_word.code_value;
    assign o_out.digits_entered = r_out_word.digits_entered;

    kce_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    kce_code_store #(
        .CODE_LENGTH (CODE_LENGTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (store_cmd),
        .i_wr_idx (store_idx),
        .o_code   (code)
    );

    kce_ctrl #(
        .CODE_LENGTH (CODE_LENGTH),
        .IDX_W       (IDX_W),
        .DCNT_W      (DCNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_word      (r_in_word),
        .i_cfg       (cfg),
        .i_code      (code),
        .o_result    (result),
        .o_store_cmd (store_cmd),
        .o_store_idx (store_idx)
    );

    // a processed poll always lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed poll lost");

    // a full pipeline with a stalled result takes no new poll
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("poll taken while pipeline full");

endmodule
